@@ rtl/valu_pkg.sv @@
`default_nettype none

package valu_pkg;

   // Field widths of the channels
   localparam int DATA_W   = 8;
   localparam int OPCODE_W = 3;
   localparam int INDEX_W  = 4;
   localparam int IMM_W    = 8;

   // Register file size
   localparam int NUM_REGISTERS_DEFAULT = 16;

   // Operation codes
   localparam logic [OPCODE_W-1:0] OP_LOAD = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_IADD = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_FADD = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_OR   = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_AND  = 3'd4;
   localparam logic [OPCODE_W-1:0] OP_XOR  = 3'd5;
   localparam logic [OPCODE_W-1:0] OP_ROTR = 3'd6;
   localparam logic [OPCODE_W-1:0] OP_KEEP = 3'd7;

   // Rotate amount uses the low bits of the immediate
   localparam int ROT_W = 3;

   // Float byte layout: sign, excess-4 exponent, 4-bit mantissa
   localparam int FLT_MANT_W  = 4;
   localparam int FLT_EXP_W   = 3;
   localparam int FLT_SIGN_B  = 7;
   // Operand magnitude (16 + m) << e, in units of 2^-8
   localparam int FLT_MAG_W   = (FLT_MANT_W + 1) + (1 << FLT_EXP_W) - 1;
   // Magnitude of a sum of two operands
   localparam int FLT_ABS_W   = FLT_MAG_W + 1;
   // Signed sum
   localparam int FLT_SUM_W   = FLT_ABS_W + 1;
   // Bit index range for the leading-one search
   localparam int FLT_MSB_W   = $clog2(FLT_ABS_W);
   // Leading-one position that maps to exponent field zero
   localparam int FLT_EXP_BASE = 4;
   localparam logic [FLT_EXP_W-1:0] FLT_EXP_MAX = '1;
   localparam logic [DATA_W-1:0]    FLT_ZERO    = 8'h00;

endpackage

`default_nettype wire

@@ rtl/valu_req_if.sv @@
`default_nettype none

interface valu_req_if;
   import valu_pkg::*;

   logic                valid;
   logic                ready;
   logic [OPCODE_W-1:0] opcode;
   logic [INDEX_W-1:0]  dest_index;
   logic [INDEX_W-1:0]  src_s_index;
   logic [INDEX_W-1:0]  src_t_index;
   logic [IMM_W-1:0]    immediate;

   modport source (
      output valid, opcode, dest_index, src_s_index, src_t_index, immediate,
      input  ready
   );

   modport sink (
      input  valid, opcode, dest_index, src_s_index, src_t_index, immediate,
      output ready
   );

endinterface

`default_nettype wire

@@ rtl/valu_rsp_if.sv @@
`default_nettype none

interface valu_rsp_if;
   import valu_pkg::*;

   logic               valid;
   logic               ready;
   logic [DATA_W-1:0]  written_value;
   logic [INDEX_W-1:0] written_index;

   modport source (
      output valid, written_value, written_index,
      input  ready
   );

   modport sink (
      input  valid, written_value, written_index,
      output ready
   );

endinterface

`default_nettype wire

@@ rtl/valu_ram.sv @@
`default_nettype none

module valu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic      [WIDTH-1:0]         rd_data_a,
   output logic      [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read ports; a read at the written address returns old data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= mem_ff[rd_addr_a];
         rd_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

`default_nettype wire

@@ rtl/valu_fadd.sv @@
`default_nettype none

module valu_fadd
   import valu_pkg::*;
(
   input  wire logic [DATA_W-1:0] operand_a,
   input  wire logic [DATA_W-1:0] operand_b,
   output logic      [DATA_W-1:0] sum
);

   logic [FLT_MAG_W-1:0]   mag_a;
   logic [FLT_MAG_W-1:0]   mag_b;
   logic signed [FLT_SUM_W-1:0] fix_a;
   logic signed [FLT_SUM_W-1:0] fix_b;
   logic signed [FLT_SUM_W-1:0] fix_sum;
   logic                   neg;
   logic [FLT_SUM_W-1:0]   abs_wide;
   logic [FLT_ABS_W-1:0]   abs_val;
   logic [FLT_MSB_W-1:0]   msb;
   logic [FLT_EXP_W-1:0]   shift;
   logic [FLT_SUM_W-1:0]   half;
   logic [FLT_SUM_W-1:0]   rounded;
   logic [FLT_SUM_W-1:0]   quot;

   // Decode both operands into signed fixed point
   always_comb begin
      mag_a = FLT_MAG_W'({1'b1, operand_a[FLT_MANT_W-1:0]})
              << operand_a[FLT_MANT_W +: FLT_EXP_W];
      mag_b = FLT_MAG_W'({1'b1, operand_b[FLT_MANT_W-1:0]})
              << operand_b[FLT_MANT_W +: FLT_EXP_W];
      fix_a = operand_a[FLT_SIGN_B] ? -$signed(FLT_SUM_W'(mag_a))
                                    :  $signed(FLT_SUM_W'(mag_a));
      fix_b = operand_b[FLT_SIGN_B] ? -$signed(FLT_SUM_W'(mag_b))
                                    :  $signed(FLT_SUM_W'(mag_b));
      fix_sum  = fix_a + fix_b;
      neg      = fix_sum[FLT_SUM_W-1];
      abs_wide = neg ? FLT_SUM_W'(-fix_sum) : FLT_SUM_W'(fix_sum);
      abs_val  = abs_wide[FLT_ABS_W-1:0];
   end

   // Find the leading one of the magnitude
   always_comb begin
      msb = '0;
      for (int i = 0; i < FLT_ABS_W; i++) begin
         if (abs_val[i]) begin
            msb = FLT_MSB_W'(i);
         end
      end
   end

   // Clamp the exponent, round half away from zero and pack the byte
   always_comb begin
      if (msb < FLT_MSB_W'(FLT_EXP_BASE)) begin
         shift = '0;
      end else if (msb > FLT_MSB_W'(FLT_EXP_BASE) + FLT_MSB_W'(FLT_EXP_MAX)) begin
         shift = FLT_EXP_MAX;
      end else begin
         shift = FLT_EXP_W'(msb - FLT_MSB_W'(FLT_EXP_BASE));
      end
      half    = (shift == '0) ? '0 : (FLT_SUM_W'(1) << (shift - FLT_EXP_W'(1)));
      rounded = FLT_SUM_W'(abs_val) + half;
      quot    = rounded >> shift;
      if (abs_val == '0) begin
         sum = FLT_ZERO;
      end else begin
         sum = {neg, shift, quot[FLT_MANT_W-1:0]};
      end
   end

endmodule

`default_nettype wire

@@ rtl/vole_alu_8bit_int_float.sv @@
// Register-file ALU: 8-bit integer, bitwise and 8-bit float operations on a
// file of NUM_REGISTERS byte registers.
// req_chan carries one operation (opcode, destination, two sources and an
// immediate); rsp_chan returns the byte written and the destination index.
// Both channels use valid/ready; a transfer happens when both are high.
// An operation's sources are read from the register file as it transfers
// into the execute stage; its result then waits in the result register.
// Throughput: one operation per cycle while rsp_chan accepts results. The
// register file is read at the request transfer and written when the
// operation leaves the execute stage; a write-to-read collision is
// forwarded, so dependent operations issue back to back.
// Reset: synchronous; empties both stages and marks every register as
// zero through per-register valid bits, so no clearing pass is needed.
// Stall: while rsp_chan is held off, one result waits in the result
// register and one operation in the execute stage; req_chan.ready drops
// only when both are occupied.
// Register indexes are reduced modulo NUM_REGISTERS; opcode 7 rewrites the
// destination with its own value and still returns a result.

`default_nettype none

module vole_alu_8bit_int_float
   import valu_pkg::*;
#(
   parameter int NUM_REGISTERS = NUM_REGISTERS_DEFAULT
) (
   input  wire logic clock,
   input  wire logic reset,
   valu_req_if.sink  req_chan,
   valu_rsp_if.source rsp_chan
);

   localparam int IDX_W = (NUM_REGISTERS > 1) ? $clog2(NUM_REGISTERS) : 1;
   localparam bit REDUCE_IDX = NUM_REGISTERS < (1 << INDEX_W);

   // Reduce a raw index modulo the file size by repeated subtraction
   function automatic logic [INDEX_W-1:0] reduce_index(input logic [INDEX_W-1:0] raw);
      logic [INDEX_W-1:0] v;
      v = raw;
      for (int i = 0; i < (1 << (INDEX_W - 1)); i++) begin
         if (REDUCE_IDX && (int'(v) >= NUM_REGISTERS)) begin
            v = v - INDEX_W'(NUM_REGISTERS);
         end
      end
      return v;
   endfunction

   // Request side
   logic               req_xfer;
   logic [IDX_W-1:0]   addr_a;
   logic [IDX_W-1:0]   addr_b;
   logic [IDX_W-1:0]   dest_addr;

   // Execute stage
   logic               s1_valid_ff, s1_valid_in;
   logic [OPCODE_W-1:0] s1_op_ff;
   logic [IDX_W-1:0]   s1_dest_ff;
   logic [IMM_W-1:0]   s1_imm_ff;
   logic               a_fwd_ff, b_fwd_ff;
   logic               a_live_ff, b_live_ff;
   logic [DATA_W-1:0]  fwd_value_ff;
   logic               s1_advance;

   // Register file
   logic [NUM_REGISTERS-1:0] live_ff, live_in;
   logic [DATA_W-1:0]  ram_a;
   logic [DATA_W-1:0]  ram_b;
   logic [DATA_W-1:0]  opnd_a;
   logic [DATA_W-1:0]  opnd_b;
   logic [DATA_W-1:0]  fadd_sum;
   logic [2*DATA_W-1:0] rot_dbl;
   logic [DATA_W-1:0]  result;

   // Result register
   logic               out_valid_ff, out_valid_in;
   logic [DATA_W-1:0]  out_value_ff;
   logic [INDEX_W-1:0] out_index_ff;

   // Handshake: the execute stage moves on when the result register frees up
   assign s1_advance      = s1_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready  = !s1_valid_ff || s1_advance;
   assign req_xfer        = req_chan.valid && req_chan.ready;

   // Source addresses; the keep opcode reads its own destination on port A
   assign dest_addr = IDX_W'(reduce_index(req_chan.dest_index));
   assign addr_a    = (req_chan.opcode == OP_KEEP) ? dest_addr
                                                   : IDX_W'(reduce_index(req_chan.src_s_index));
   assign addr_b    = IDX_W'(reduce_index(req_chan.src_t_index));

   valu_ram #(
      .WIDTH (DATA_W),
      .DEPTH (NUM_REGISTERS)
   ) u_regfile (
      .clock     (clock),
      .wr_en     (s1_advance),
      .wr_addr   (s1_dest_ff),
      .wr_data   (result),
      .rd_en     (req_xfer),
      .rd_addr_a (addr_a),
      .rd_addr_b (addr_b),
      .rd_data_a (ram_a),
      .rd_data_b (ram_b)
   );

   // Mark registers written since reset
   always_comb begin
      live_in = live_ff;
      if (s1_advance) begin
         live_in[s1_dest_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff <= '0;
      end else begin
         live_ff <= live_in;
      end
   end

   // Load the execute stage; forward a write that lands in the same cycle
   assign s1_valid_in = req_xfer || (s1_valid_ff && !s1_advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_op_ff     <= req_chan.opcode;
         s1_dest_ff   <= dest_addr;
         s1_imm_ff    <= req_chan.immediate;
         a_fwd_ff     <= s1_advance && (s1_dest_ff == addr_a);
         b_fwd_ff     <= s1_advance && (s1_dest_ff == addr_b);
         a_live_ff    <= live_ff[addr_a];
         b_live_ff    <= live_ff[addr_b];
         fwd_value_ff <= result;
      end
   end

   // Pick operands: forwarded byte, stored byte, or zero if never written
   assign opnd_a = a_fwd_ff ? fwd_value_ff : (a_live_ff ? ram_a : '0);
   assign opnd_b = b_fwd_ff ? fwd_value_ff : (b_live_ff ? ram_b : '0);

   valu_fadd u_fadd (
      .operand_a (opnd_a),
      .operand_b (opnd_b),
      .sum       (fadd_sum)
   );

   assign rot_dbl = {opnd_a, opnd_a} >> s1_imm_ff[ROT_W-1:0];

   // Select the operation result
   always_comb begin
      case (s1_op_ff)
         OP_LOAD: result = s1_imm_ff;
         OP_IADD: result = opnd_a + opnd_b;
         OP_FADD: result = fadd_sum;
         OP_OR:   result = opnd_a | opnd_b;
         OP_AND:  result = opnd_a & opnd_b;
         OP_XOR:  result = opnd_a ^ opnd_b;
         OP_ROTR: result = rot_dbl[DATA_W-1:0];
         default: result = opnd_a;
      endcase
   end

   // Result register: hold while the receiver stalls
   assign out_valid_in = s1_advance || (out_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         out_value_ff <= result;
         out_index_ff <= INDEX_W'(s1_dest_ff);
      end
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.written_value = out_value_ff;
   assign rsp_chan.written_index = out_index_ff;

endmodule

`default_nettype wire
